// ===== sv/nns_pkg.sv =====
// Shared types and constants of the nearest-neighbour scaler.
// Used by every module of the block but nns_ram; depends on nothing.
package nns_pkg;

  localparam int unsigned PIX_W       = 32;
  localparam int unsigned CRD_W       = 12;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CERR_W      = 16;
  localparam int unsigned RERR_W      = 24;
  localparam int unsigned ROWS_MAX    = 4095;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [DIM_W-1:0] SRC_W_RST = 13'd640;
  localparam logic [DIM_W-1:0] SRC_H_RST = 13'd480;
  localparam logic [DIM_W-1:0] DST_W_RST = 13'd640;
  localparam logic [DIM_W-1:0] DST_H_RST = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_W = 2'd0,
    REG_SRC_H = 2'd1,
    REG_DST_W = 2'd2,
    REG_DST_H = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic             run_last;
    logic             frame_last;
    logic             dropped;
  } res_t;

endpackage

// ===== sv/nns_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module nns_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/nns_front.sv =====
// Front end: accepts input items, decodes them into commands and queues them.
// Depends on nns_pkg.
module nns_front #(
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      mode_i,
  input  logic [nns_pkg::PIX_W-1:0] pixel_in_i,
  output logic                      q_valid_o,
  output nns_pkg::cmd_e             q_cmd_o,
  output logic [PIXEL_BITS-1:0]     q_pixel_o,
  input  logic                      q_pop_i
);

  localparam int unsigned QD = nns_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = (QD > 1) ? $clog2(QD) : 1;
  localparam int unsigned CW = $clog2(QD + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QD - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QD);

  nns_pkg::cmd_e           cmd_q [QD];
  logic [PIXEL_BITS-1:0]   pix_q [QD];
  logic [PW-1:0]           wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    push;
  nns_pkg::cmd_e           cmd_in;

  assign in_ready_o = (cnt_q != CNT_FULL);
  assign push       = in_valid_i && in_ready_o;
  assign cmd_in     = mode_i ? nns_pkg::CMD_TICK : nns_pkg::CMD_PUSH;

  assign q_valid_o  = (cnt_q != '0);
  assign q_cmd_o    = cmd_q[rptr_q];
  assign q_pixel_o  = pix_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1);
    end
    if (q_pop_i) begin
      rptr_d = (rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1);
    end
    cnt_d = cnt_q + CW'(push) - CW'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wptr_q] <= cmd_in;
      pix_q[wptr_q] <= pixel_in_i[PIXEL_BITS-1:0];
    end
  end

endmodule

// ===== sv/nns_back.sv =====
// Back end: steps pushes and replay ticks column by column, owns the line
// buffer and the output register. Depends on nns_pkg and nns_ram.
module nns_back #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_REP    = 16,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nns_pkg::cfg_t         cfg_i,
  input  logic                  q_valid_i,
  input  nns_pkg::cmd_e         q_cmd_i,
  input  logic [PIXEL_BITS-1:0] q_pixel_i,
  output logic                  q_pop_o,
  output logic                  res_valid_o,
  input  logic                  res_ready_i,
  output nns_pkg::res_t         res_o
);

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned NW = $clog2(MAX_REP + 1);
  localparam int unsigned DW = nns_pkg::DIM_W;
  localparam int unsigned CW = nns_pkg::CERR_W;
  localparam int unsigned CS = CW + 1;
  localparam int unsigned RW = nns_pkg::RERR_W;
  localparam int unsigned XW = nns_pkg::CRD_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;

  localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_WIDTH - 1);
  localparam logic [NW-1:0] REP_LAST  = NW'(MAX_REP - 1);
  localparam logic [NW-1:0] REP_MAX   = NW'(MAX_REP);
  localparam logic [XW-1:0] ROWS_LAST = XW'(nns_pkg::ROWS_MAX - 1);

  logic [1:0]             st_q, st_d;
  logic [DW-1:0]          src_col_q, src_col_d, src_row_q, src_row_d;
  logic [DW-1:0]          out_col_q, out_col_d;
  logic [XW-1:0]          out_row_q, out_row_d;
  logic [CW-1:0]          col_err_q, col_err_d;
  logic signed [RW-1:0]   row_err_q, row_err_d;
  logic                   pend_q, pend_d;
  logic [XW-1:0]          rep_cnt_q, rep_cnt_d;
  logic [AW-1:0]          addr_q, addr_d;
  logic                   active_q, active_d;
  logic [NW-1:0]          n_q, n_d;
  logic [PIXEL_BITS-1:0]  run_pix_q, run_pix_d;
  logic                   res_valid_q, res_valid_d;
  nns_pkg::res_t          res_q, res_d;
  logic                   byp_q, byp_d;
  logic [PIXEL_BITS-1:0]  byp_data_q;

  logic                   we;
  logic [PIXEL_BITS-1:0]  ram_rdata, line_pix;

  logic [CS-1:0]          sw_e, dw_e, dw2_e, ce, ce1, ce1m, cem;
  logic                   ce_lt, ce1_ge, ce1_ge2, ce_ge2;
  logic signed [RW-1:0]   sh_s, dh_s, re_a, re_am, re_m;
  logic                   re_lt_dh;
  logic [DW-1:0]          src_col1, src_row1, out_col1, push_col1;
  logic                   src_end, row_wrap, oc_end;
  logic [XW-1:0]          out_row1;
  logic [AW-1:0]          addr1;
  logic                   frame_last;

  logic                   oslot, take, in_run, run_go, drop_go, tick_go;
  logic                   run_act, fin, pend_new;
  logic [NW-1:0]          run_n;
  logic [PIXEL_BITS-1:0]  run_pix;

  nns_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (addr_q),
    .wdata_i (q_pixel_i),
    .raddr_i (addr_d),
    .rdata_o (ram_rdata)
  );

  assign line_pix = byp_q ? byp_data_q : ram_rdata;

  assign sw_e    = CS'(cfg_i.src_w);
  assign dw_e    = CS'(cfg_i.dst_w);
  assign dw2_e   = CS'({cfg_i.dst_w, 1'b0});
  assign ce      = CS'(col_err_q);
  assign ce1     = ce + sw_e;
  assign ce1m    = ce + sw_e - dw_e;
  assign cem     = ce - dw_e;
  assign ce_lt   = ce < dw_e;
  assign ce1_ge  = ce1 >= dw_e;
  assign ce1_ge2 = ce1 >= dw2_e;
  assign ce_ge2  = ce >= dw2_e;

  assign sh_s     = RW'(cfg_i.src_h);
  assign dh_s     = RW'(cfg_i.dst_h);
  assign re_a     = row_err_q + sh_s;
  assign re_am    = row_err_q + sh_s - dh_s;
  assign re_m     = row_err_q - dh_s;
  assign re_lt_dh = row_err_q < dh_s;

  assign src_col1  = src_col_q + DW'(1);
  assign src_row1  = src_row_q + DW'(1);
  assign src_end   = src_col1 >= cfg_i.src_w;
  assign row_wrap  = src_row1 >= cfg_i.src_h;
  assign out_col1  = out_col_q + DW'(1);
  assign push_col1 = DW'(out_col_q[XW-1:0] + XW'(1));
  assign oc_end    = out_col1 >= cfg_i.dst_w;
  assign out_row1  = out_row_q + XW'(1);
  assign addr1     = (addr_q == ADDR_LAST) ? '0 : addr_q + AW'(1);

  assign frame_last = (out_col_q == cfg_i.dst_w - DW'(1)) &&
                      (DW'(out_row_q) == cfg_i.dst_h - DW'(1));

  assign oslot   = !res_valid_q || res_ready_i;
  assign take    = (st_q == ST_IDLE) && q_valid_i && oslot;
  assign in_run  = (st_q == ST_RUN);
  assign run_go  = (take && (q_cmd_i == nns_pkg::CMD_PUSH) && !pend_q) || (in_run && oslot);
  assign drop_go = take && (q_cmd_i == nns_pkg::CMD_PUSH) && pend_q;
  assign tick_go = take && (q_cmd_i == nns_pkg::CMD_TICK) && pend_q;
  assign run_act = in_run ? active_q : re_lt_dh;
  assign run_n   = in_run ? n_q : '0;
  assign run_pix = in_run ? run_pix_q : q_pixel_i;

  always_comb begin
    st_d        = st_q;
    src_col_d   = src_col_q;
    src_row_d   = src_row_q;
    out_col_d   = out_col_q;
    out_row_d   = out_row_q;
    col_err_d   = col_err_q;
    row_err_d   = row_err_q;
    pend_d      = pend_q;
    rep_cnt_d   = rep_cnt_q;
    addr_d      = addr_q;
    active_d    = active_q;
    n_d         = n_q;
    run_pix_d   = run_pix_q;
    res_valid_d = res_valid_q && !res_ready_i;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    we          = 1'b0;
    fin         = 1'b0;
    pend_new    = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (take) begin
          q_pop_o = 1'b1;
        end
        if (run_go) begin
          we        = 1'b1;
          active_d  = re_lt_dh;
          run_pix_d = q_pixel_i;
        end
      end
      ST_RUN: begin
      end
      ST_STEP: begin
        col_err_d = cem[CW-1:0];
        src_col_d = src_col1;
        addr_d    = addr1;
        if (!ce_ge2) begin
          st_d = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase

    if (drop_go) begin
      res_valid_d      = 1'b1;
      res_d            = '0;
      res_d.run_last   = 1'b1;
      res_d.dropped    = 1'b1;
    end

    if (run_go) begin
      if (ce_lt) begin
        if (run_act && (run_n < REP_MAX)) begin
          res_valid_d      = 1'b1;
          res_d.pixel      = nns_pkg::PIX_W'(run_pix);
          res_d.x          = out_col_q[XW-1:0];
          res_d.y          = out_row_q;
          res_d.run_last   = (run_n == REP_LAST) || ce1_ge;
          res_d.frame_last = frame_last;
          res_d.dropped    = 1'b0;
        end
        out_col_d = push_col1;
        n_d       = (run_n == REP_MAX) ? run_n : run_n + NW'(1);
        fin       = ce1_ge;
        col_err_d = ce1_ge ? ce1m[CW-1:0] : ce1[CW-1:0];
      end else begin
        fin       = 1'b1;
        col_err_d = cem[CW-1:0];
      end
      st_d = fin ? ST_IDLE : ST_RUN;
      if (fin) begin
        src_col_d = src_col1;
        addr_d    = addr1;
        if (src_end) begin
          src_col_d = '0;
          col_err_d = '0;
          out_col_d = '0;
          addr_d    = '0;
          pend_new  = run_act && re_am[RW-1];
          if (run_act) begin
            out_row_d = out_row1;
            pend_d    = pend_new;
            rep_cnt_d = '0;
          end
          row_err_d = run_act ? re_am : re_m;
          src_row_d = src_row1;
          if (row_wrap) begin
            src_row_d = '0;
            if (!pend_new) begin
              out_row_d = '0;
              row_err_d = '0;
            end
          end
        end
      end
    end

    if (tick_go) begin
      res_valid_d      = 1'b1;
      res_d.pixel      = nns_pkg::PIX_W'(line_pix);
      res_d.x          = out_col_q[XW-1:0];
      res_d.y          = out_row_q;
      res_d.run_last   = 1'b1;
      res_d.frame_last = frame_last;
      res_d.dropped    = 1'b0;
      if (oc_end) begin
        out_col_d = '0;
        src_col_d = '0;
        col_err_d = '0;
        addr_d    = '0;
        out_row_d = out_row1;
        row_err_d = re_a;
        rep_cnt_d = rep_cnt_q + XW'(1);
        pend_new  = (rep_cnt_q != ROWS_LAST) && re_a[RW-1];
        pend_d    = pend_new;
        if (!pend_new && (src_row_q == '0)) begin
          out_row_d = '0;
          row_err_d = '0;
        end
      end else begin
        out_col_d = out_col1;
        if (ce1_ge) begin
          col_err_d = ce1m[CW-1:0];
          src_col_d = src_col1;
          addr_d    = addr1;
          if (ce1_ge2) begin
            st_d = ST_STEP;
          end
        end else begin
          col_err_d = ce1[CW-1:0];
        end
      end
    end

    byp_d = we && (addr_q == addr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      src_col_q   <= '0;
      src_row_q   <= '0;
      out_col_q   <= '0;
      out_row_q   <= '0;
      col_err_q   <= '0;
      row_err_q   <= '0;
      pend_q      <= 1'b0;
      rep_cnt_q   <= '0;
      addr_q      <= '0;
      active_q    <= 1'b0;
      n_q         <= '0;
      res_valid_q <= 1'b0;
      byp_q       <= 1'b0;
    end else begin
      st_q        <= st_d;
      src_col_q   <= src_col_d;
      src_row_q   <= src_row_d;
      out_col_q   <= out_col_d;
      out_row_q   <= out_row_d;
      col_err_q   <= col_err_d;
      row_err_q   <= row_err_d;
      pend_q      <= pend_d;
      rep_cnt_q   <= rep_cnt_d;
      addr_q      <= addr_d;
      active_q    <= active_d;
      n_q         <= n_d;
      res_valid_q <= res_valid_d;
      byp_q       <= byp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_pix_q  <= run_pix_d;
    res_q      <= res_d;
    byp_data_q <= q_pixel_i;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== sv/nearest_neighbor_scaler_core.sv =====
// Top level of the nearest-neighbour scaler: configuration registers, front
// end queue and back end stepper. Depends on nns_pkg, nns_front and nns_back.
//
// Source pixels are pushed in raster order (mode 0) and kept in a line buffer
// of MAX_WIDTH words; replay ticks (mode 1) emit further destination rows of
// the current source row from that buffer. The back end steps one destination
// column per clock while the output register is free: a push steps through
// the destination columns that its source column spans, with up to MAX_REP of
// them emitting a pixel. A replay tick emits one pixel and, when the source
// row is more than twice as wide as the destination row, steps over further
// source columns beyond the first. A two-entry queue takes input at one item
// per clock while the stepper works, as long as it is not full, and the output
// register holds a result while the next is prepared. The line buffer needs no
// clearing pass. A zero in a size register acts as one.
module nearest_neighbor_scaler_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_REP    = 16,
  parameter int unsigned PIXEL_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nns_pkg::DIM_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [nns_pkg::PIX_W-1:0]     pixel_in_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nns_pkg::PIX_W-1:0]     pixel_out_o,
  output logic [nns_pkg::CRD_W-1:0]     dst_x_o,
  output logic [nns_pkg::CRD_W-1:0]     dst_y_o,
  output logic                          run_last_o,
  output logic                          frame_last_o,
  output logic                          dropped_o
);

  nns_pkg::cfg_t               cfg_q, cfg_d;
  logic [nns_pkg::DIM_W-1:0]   cfg_eff;
  logic                        q_valid, q_pop;
  nns_pkg::cmd_e               q_cmd;
  logic [PIXEL_BITS-1:0]       q_pixel;
  nns_pkg::res_t               res;

  assign cfg_ready_o = 1'b1;
  assign cfg_eff     = (cfg_data_i == '0) ? nns_pkg::DIM_W'(1) : cfg_data_i;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (nns_pkg::cfg_reg_e'(cfg_index_i))
        nns_pkg::REG_SRC_W: cfg_d.src_w = cfg_eff;
        nns_pkg::REG_SRC_H: cfg_d.src_h = cfg_eff;
        nns_pkg::REG_DST_W: cfg_d.dst_w = cfg_eff;
        nns_pkg::REG_DST_H: cfg_d.dst_h = cfg_eff;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_w <= nns_pkg::SRC_W_RST;
      cfg_q.src_h <= nns_pkg::SRC_H_RST;
      cfg_q.dst_w <= nns_pkg::DST_W_RST;
      cfg_q.dst_h <= nns_pkg::DST_H_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  nns_front #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .pixel_in_i (pixel_in_i),
    .q_valid_o  (q_valid),
    .q_cmd_o    (q_cmd),
    .q_pixel_o  (q_pixel),
    .q_pop_i    (q_pop)
  );

  nns_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_REP    (MAX_REP),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pixel_i   (q_pixel),
    .q_pop_o     (q_pop),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign pixel_out_o  = res.pixel;
  assign dst_x_o      = res.x;
  assign dst_y_o      = res.y;
  assign run_last_o   = res.run_last;
  assign frame_last_o = res.frame_last;
  assign dropped_o    = res.dropped;

endmodule

// ===== sv/nns_checker.sv =====
// Port-level checks on the scaler's result channel, bound to the top level.
// Depends on nns_pkg and nearest_neighbor_scaler_core.
module nns_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input logic [nns_pkg::PIX_W-1:0] pixel_out_o,
  input logic [nns_pkg::CRD_W-1:0] dst_x_o,
  input logic [nns_pkg::CRD_W-1:0] dst_y_o,
  input logic                      run_last_o,
  input logic                      frame_last_o,
  input logic                      dropped_o
);

  a_drop_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dropped_o |-> run_last_o && !frame_last_o &&
      (pixel_out_o == '0) && (dst_x_o == '0) && (dst_y_o == '0))
    else $error("refused push result not in its fixed form");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pixel_out_o) &&
      $stable(dst_x_o) && $stable(dst_y_o) && $stable(run_last_o))
    else $error("result changed while stalled");

  a_run_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !run_last_o |=> out_valid_o && !dropped_o &&
      (dst_y_o == $past(dst_y_o)) &&
      (dst_x_o == nns_pkg::CRD_W'($past(dst_x_o) + nns_pkg::CRD_W'(1))))
    else $error("run did not continue on the next column");

endmodule

bind nearest_neighbor_scaler_core nns_checker u_nns_checker (.*);
